// File: rtl/core/cbpe_pkg.sv
`default_nettype none
package cbpe_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int T_FRAC_BITS = 16;

   localparam int T_W    = T_FRAC_BITS + 1;
   localparam int SQ_W   = 2 * T_W;
   localparam int CU_W   = 3 * T_W;
   localparam int LO_W   = CU_W / 2;
   localparam int HI_W   = CU_W - LO_W;
   localparam int PL_W   = COORD_WIDTH + LO_W + 1;
   localparam int PH_W   = COORD_WIDTH + HI_W + 1;
   localparam int SHIFT  = 3 * T_FRAC_BITS;
   localparam int ACC_W  = COORD_WIDTH + CU_W + 4;
   localparam int RES_W  = ACC_W - SHIFT;
   localparam int STAGES = 7;

   localparam int REQ_DATA_W = ((T_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
   localparam int CSR_IDX_W  = 8;

   typedef logic        [T_W-1:0]         tparam_type;
   typedef logic        [SQ_W-1:0]        square_type;
   typedef logic        [CU_W-1:0]        weight_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [PL_W-1:0]        plo_type;
   typedef logic signed [PH_W-1:0]        phi_type;
   typedef logic signed [ACC_W-1:0]       acc_type;
   typedef logic signed [RES_W-1:0]       res_type;

   localparam tparam_type T_ONE = tparam_type'(1) << T_FRAC_BITS;
   localparam acc_type    HALF  = acc_type'(1) <<< (SHIFT - 1);
   localparam res_type    RES_MAX = res_type'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam res_type    RES_MIN = res_type'(-(64'sd1 <<< (COORD_WIDTH - 1)));

   localparam logic [CSR_IDX_W-1:0] CSR_P0_X = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_P0_Y = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_P1_X = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_P1_Y = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_P2_X = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_P2_Y = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_P3_X = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_P3_Y = 8'd7;

endpackage
`default_nettype wire

// File: rtl/core/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator, seven register stages from request to response.
// Throughput: one request per cycle unless rsp_tready stalls the pipeline; the 34x17-bit
// weight and 16x26/16x27-bit coordinate multipliers are each used once per request.
// Reset (synchronous, active high) clears all control points to zero and
// empties the pipeline.
`default_nettype none
module cubic_bezier_point_eval (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [cbpe_pkg::REQ_DATA_W-1:0]      req_tdata,  // t_param, zero pad
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [cbpe_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // curve_x, curve_y
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [cbpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [cbpe_pkg::COORD_WIDTH-1:0]     csr_wdata
);

   cbpe_pkg::coord_type pt_ff [2][4];

   logic [cbpe_pkg::STAGES:1] v_ff;
   logic [cbpe_pkg::STAGES:1] en;

   cbpe_pkg::tparam_type t1_ff, u1_ff, t1_in;
   cbpe_pkg::tparam_type t2_ff, u2_ff;
   cbpe_pkg::square_type tt2_ff, uu2_ff;
   cbpe_pkg::weight_type w3_ff [4];
   cbpe_pkg::plo_type    plo4_ff [2][4];
   cbpe_pkg::phi_type    phi4_ff [2][4];
   cbpe_pkg::acc_type    term5_ff [2][4];
   cbpe_pkg::acc_type    term5_in [2][4];
   cbpe_pkg::res_type    res6_ff [2];
   cbpe_pkg::acc_type    sum6_in [2];
   cbpe_pkg::coord_type  out7_ff [2];
   cbpe_pkg::coord_type  out7_in [2];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < 4; k++) begin
               pt_ff[a][k] <= '0;
            end
         end
      end else if (csr_valid) begin
         case (csr_index)
            cbpe_pkg::CSR_P0_X: pt_ff[0][0] <= csr_wdata;
            cbpe_pkg::CSR_P0_Y: pt_ff[1][0] <= csr_wdata;
            cbpe_pkg::CSR_P1_X: pt_ff[0][1] <= csr_wdata;
            cbpe_pkg::CSR_P1_Y: pt_ff[1][1] <= csr_wdata;
            cbpe_pkg::CSR_P2_X: pt_ff[0][2] <= csr_wdata;
            cbpe_pkg::CSR_P2_Y: pt_ff[1][2] <= csr_wdata;
            cbpe_pkg::CSR_P3_X: pt_ff[0][3] <= csr_wdata;
            cbpe_pkg::CSR_P3_Y: pt_ff[1][3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance a stage when it is empty or its successor advances
   always_comb begin
      en[cbpe_pkg::STAGES] = !v_ff[cbpe_pkg::STAGES] || rsp_tready;
      for (int k = cbpe_pkg::STAGES - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[1];
   assign rsp_tvalid = v_ff[cbpe_pkg::STAGES];
   assign rsp_tdata  = cbpe_pkg::RSP_DATA_W'({out7_ff[1], out7_ff[0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = cbpe_pkg::STAGES; k >= 2; k--) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         if (en[1]) begin
            v_ff[1] <= req_tvalid;
         end
      end
   end

   always_comb begin
      t1_in = req_tdata[cbpe_pkg::T_W-1:0];
      if (t1_in > cbpe_pkg::T_ONE) begin
         t1_in = cbpe_pkg::T_ONE;
      end
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         for (int k = 0; k < 4; k++) begin
            term5_in[a][k] = (cbpe_pkg::acc_type'(phi4_ff[a][k]) <<< cbpe_pkg::LO_W)
                           + cbpe_pkg::acc_type'(plo4_ff[a][k]);
         end
         term5_in[a][1] = term5_in[a][1] + (term5_in[a][1] <<< 1);
         term5_in[a][2] = term5_in[a][2] + (term5_in[a][2] <<< 1);
         sum6_in[a] = term5_ff[a][0] + term5_ff[a][1] + term5_ff[a][2]
                    + term5_ff[a][3] + cbpe_pkg::HALF;
         if (res6_ff[a] > cbpe_pkg::RES_MAX) begin
            out7_in[a] = cbpe_pkg::coord_type'(cbpe_pkg::RES_MAX);
         end else if (res6_ff[a] < cbpe_pkg::RES_MIN) begin
            out7_in[a] = cbpe_pkg::coord_type'(cbpe_pkg::RES_MIN);
         end else begin
            out7_in[a] = res6_ff[a][cbpe_pkg::COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         t1_ff <= t1_in;
         u1_ff <= cbpe_pkg::T_ONE - t1_in;
      end
      if (en[2]) begin
         t2_ff  <= t1_ff;
         u2_ff  <= u1_ff;
         tt2_ff <= cbpe_pkg::SQ_W'(t1_ff) * cbpe_pkg::SQ_W'(t1_ff);
         uu2_ff <= cbpe_pkg::SQ_W'(u1_ff) * cbpe_pkg::SQ_W'(u1_ff);
      end
      if (en[3]) begin
         w3_ff[0] <= cbpe_pkg::CU_W'(uu2_ff) * cbpe_pkg::CU_W'(u2_ff);
         w3_ff[1] <= cbpe_pkg::CU_W'(uu2_ff) * cbpe_pkg::CU_W'(t2_ff);
         w3_ff[2] <= cbpe_pkg::CU_W'(tt2_ff) * cbpe_pkg::CU_W'(u2_ff);
         w3_ff[3] <= cbpe_pkg::CU_W'(tt2_ff) * cbpe_pkg::CU_W'(t2_ff);
      end
      if (en[4]) begin
         for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < 4; k++) begin
               plo4_ff[a][k] <= cbpe_pkg::plo_type'(pt_ff[a][k])
                  * cbpe_pkg::plo_type'($signed({1'b0, w3_ff[k][cbpe_pkg::LO_W-1:0]}));
               phi4_ff[a][k] <= cbpe_pkg::phi_type'(pt_ff[a][k])
                  * cbpe_pkg::phi_type'($signed({1'b0,
                       w3_ff[k][cbpe_pkg::CU_W-1:cbpe_pkg::LO_W]}));
            end
         end
      end
      if (en[5]) begin
         term5_ff <= term5_in;
      end
      if (en[6]) begin
         for (int a = 0; a < 2; a++) begin
            res6_ff[a] <= sum6_in[a][cbpe_pkg::ACC_W-1:cbpe_pkg::SHIFT];
         end
      end
      if (en[7]) begin
         out7_ff <= out7_in;
      end
   end

endmodule
`default_nettype wire
